/* rtl/j2dst_pkg.sv */
// Shared types, sizes and codes for the Jacobi 2-D stencil unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package j2dst_pkg;

   // Grid limits and derived counter widths
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int SIZE_W   = 11;   // width of the size registers
   localparam int IDX_W    = 10;   // width of the reported row and column

   // Datapath widths
   localparam int DATA_W  = 32;               // Q16.16 sample and scale
   localparam int FRAC_W  = 16;
   localparam int SUM_W   = DATA_W + 2;       // four-term sum
   localparam int ACC_W   = SUM_W + DATA_W - 1; // magnitude product
   localparam int MAG_W   = ACC_W - FRAC_W;
   localparam int CHUNK_W = 16;               // scale bits per multiply cell
   localparam int N_CELLS = DATA_W / CHUNK_W;

   localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
   localparam logic [DATA_W-1:0] POS_LIMIT  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIMIT  = {1'b1, {(DATA_W-1){1'b0}}};

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STENCIL_SCALE = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(1024);
   localparam logic [DATA_W-1:0] SCALE_RESET = DATA_W'(16384);
   localparam logic [SIZE_W-1:0] SIZE_MIN    = SIZE_W'(3);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     frame_start;
   } j2dst_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] updated_value;
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic                     frame_last;
   } j2dst_rsp_type;

   // Clamped sizes and sign/magnitude scale, as seen by the datapath
   typedef struct packed {
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic              scale_neg;
      logic [DATA_W-1:0] scale_mag;
   } j2dst_cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } j2dst_tag_type;

   // Item moving down the multiply chain
   typedef struct packed {
      logic              neg;
      logic [SUM_W-1:0]  a;     // magnitude of the neighbor sum
      logic [DATA_W-1:0] b;     // scale magnitude, next chunk on top
      logic [ACC_W-1:0]  acc;
      j2dst_tag_type     tag;
   } j2dst_cell_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int maxv);
      logic [SIZE_W-1:0] res;
      res = v;
      if (v < SIZE_MIN) res = SIZE_MIN;
      else if (32'(v) > maxv) res = SIZE_W'(maxv);
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/j2dst_front.sv */
// Raster position tracking, the two line stores and the neighbor sum.
// Depends on j2dst_pkg; feeds the first multiply cell.
`default_nettype none

module j2dst_front import j2dst_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire j2dst_cfg_type  cfg,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire j2dst_req_type  in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output j2dst_cell_type      out_data
);

   logic [COL_W-1:0]  pos_col_ff, pos_col_in, cur_col, east_col;
   logic [ROW_W-1:0]  pos_row_ff, pos_row_in, cur_row;
   logic [SIZE_W-1:0] col_ext, row_ext;
   logic              accept, produce, last, fwd;

   logic [DATA_W-1:0] prev_mem [MAX_COLS];
   logic [DATA_W-1:0] sec_mem  [MAX_COLS];
   logic [DATA_W-1:0] prev_rd_ff, east_rd_ff, sec_rd_ff, west_ff, north;

   logic                     s1_v_ff, s1_produce_ff, s1_fwd_ff, s1_adv;
   logic signed [DATA_W-1:0] s1_sample_ff;
   logic [COL_W-1:0]         s1_col_ff;
   j2dst_tag_type            s1_tag_ff;

   logic                    s2_v_ff, s2_ready;
   logic signed [SUM_W-1:0] s2_sum_ff, sum_in;
   j2dst_tag_type           s2_tag_ff;

   logic           s3_v_ff, s3_ready, sum_neg;
   j2dst_cell_type s3_data_ff, s3_data_in;

   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_adv   = s1_v_ff && (!s1_produce_ff || s2_ready);
   assign in_ready = !s1_v_ff || s1_adv;
   assign accept   = in_valid && in_ready;

   // Position of this sample and the next one
   always_comb begin
      cur_row  = in_data.frame_start ? '0 : pos_row_ff;
      cur_col  = in_data.frame_start ? '0 : pos_col_ff;
      col_ext  = SIZE_W'(cur_col);
      row_ext  = SIZE_W'(cur_row);
      east_col = cur_col + COL_W'(1);
      produce  = (row_ext >= SIZE_W'(2)) && (col_ext >= SIZE_W'(1)) &&
                 (col_ext + SIZE_W'(2) <= cfg.cols);
      last     = (row_ext + SIZE_W'(1) == cfg.rows) && (col_ext + SIZE_W'(2) == cfg.cols);
      fwd      = s1_v_ff && (s1_col_ff == cur_col);
      if (col_ext + SIZE_W'(1) >= cfg.cols) begin
         pos_col_in = '0;
         pos_row_in = (row_ext + SIZE_W'(1) >= cfg.rows) ? '0 : cur_row + ROW_W'(1);
      end else begin
         pos_col_in = cur_col + COL_W'(1);
         pos_row_in = cur_row;
      end
   end

   // Line stores: read old row r-1 and r-2 at this column, write the new sample
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_mem[cur_col] <= in_data.sample;
         prev_rd_ff        <= prev_mem[cur_col];
         east_rd_ff        <= prev_mem[east_col];
      end
   end

   // Row r-2 store takes the displaced row r-1 value one stage later
   always_ff @(posedge clock) begin
      if (accept) begin
         sec_rd_ff <= sec_mem[cur_col];
      end
      if (s1_adv) begin
         sec_mem[s1_col_ff] <= prev_rd_ff;
      end
   end

   // North comes from the stage ahead when it still holds the same column
   always_comb begin
      north  = s1_fwd_ff ? west_ff : sec_rd_ff;
      sum_in = SUM_W'($signed(north)) + SUM_W'(s1_sample_ff) +
               SUM_W'($signed(west_ff)) + SUM_W'($signed(east_rd_ff));
   end

   always_comb begin
      sum_neg        = s2_sum_ff[SUM_W-1];
      s3_data_in.neg = sum_neg ^ cfg.scale_neg;
      s3_data_in.a   = sum_neg ? SUM_W'(-s2_sum_ff) : SUM_W'(s2_sum_ff);
      s3_data_in.b   = cfg.scale_mag;
      s3_data_in.acc = '0;
      s3_data_in.tag = s2_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_col_ff <= '0;
         pos_row_ff <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         west_ff    <= '0;
      end else begin
         if (accept) begin
            pos_col_ff <= pos_col_in;
            pos_row_ff <= pos_row_in;
         end
         if (in_ready) s1_v_ff <= in_valid;
         if (s1_adv) west_ff <= prev_rd_ff;
         if (s2_ready) s2_v_ff <= s1_v_ff && s1_produce_ff;
         if (s3_ready) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_produce_ff <= produce;
         s1_fwd_ff     <= fwd;
         s1_sample_ff  <= in_data.sample;
         s1_col_ff     <= cur_col;
         s1_tag_ff.row <= IDX_W'(cur_row - ROW_W'(1));
         s1_tag_ff.col <= IDX_W'(cur_col);
         s1_tag_ff.last <= last;
      end
      if (s2_ready && s1_v_ff && s1_produce_ff) begin
         s2_sum_ff <= sum_in;
         s2_tag_ff <= s1_tag_ff;
      end
      if (s3_ready && s2_v_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

/* rtl/j2dst_mac_cell.sv */
// One multiply cell: shifts the running product up a chunk and adds
// the sum magnitude times the top chunk of the scale. Depends on j2dst_pkg.
`default_nettype none

module j2dst_mac_cell import j2dst_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire j2dst_cell_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output j2dst_cell_type      out_data
);

   logic [SUM_W+CHUNK_W-1:0] prod;
   logic                     v_ff;
   j2dst_cell_type           data_ff, data_in;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      prod        = in_data.a * in_data.b[DATA_W-1 -: CHUNK_W];
      data_in     = in_data;
      data_in.acc = {in_data.acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
      data_in.b   = {in_data.b[DATA_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/j2dst_round_sat.sv */
// Output stage: round the Q33.32 product to Q16.16, saturate, apply sign.
// Depends on j2dst_pkg; drives the result channel.
`default_nettype none

module j2dst_round_sat import j2dst_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire j2dst_cell_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output j2dst_rsp_type       out_data
);

   logic [ACC_W-1:0]  rnd;
   logic [MAG_W-1:0]  mag;
   logic [DATA_W-1:0] value;
   logic              v_ff;
   j2dst_rsp_type     data_ff;

   assign in_ready = !v_ff || out_ready;

   // Ties round away from zero since the magnitude is rounded
   always_comb begin
      rnd = in_data.acc + ROUND_HALF;
      mag = rnd[ACC_W-1:FRAC_W];
      if (in_data.neg) begin
         value = (mag >= MAG_W'(NEG_LIMIT)) ? NEG_LIMIT : (~mag[DATA_W-1:0] + DATA_W'(1));
      end else begin
         value = (mag >= MAG_W'(POS_LIMIT)) ? POS_LIMIT : mag[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff.updated_value <= $signed(value);
         data_ff.out_row       <= in_data.tag.row;
         data_ff.out_col       <= in_data.tag.col;
         data_ff.frame_last    <= in_data.tag.last;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/jacobi_2d_four_point_stencil_unit.sv */
// Top level of the streaming Jacobi four-point stencil unit.
// Depends on j2dst_pkg, j2dst_front, j2dst_mac_cell and j2dst_round_sat.
//
//   Channel   Ports                          Direction  Item
//   --------  -----------------------------  ---------  ---------------------------------
//   request   req_valid req_ready req_data   in         one Q16.16 sample, frame start
//   response  rsp_valid rsp_ready rsp_data   out        updated interior point + position
//   csr       csr_valid csr_ready csr_index  in         register write (rows, cols, scale)
//             csr_wdata
//
// One sample enters per clock while req_ready is high. A result is registered from
// the sample that completes its south neighbor through one line-store read, the
// neighbor sum, the sign split, one multiply cell per 16-bit scale chunk, and rounding.
// Synchronous reset clears position, pipeline valids and registers to their
// defaults; line stores are not cleared. Each stage holds its item while the
// next one is full, so a stalled response only stops intake once every stage
// is occupied. The csr port is always ready.
`default_nettype none

module jacobi_2d_four_point_stencil_unit import j2dst_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire j2dst_req_type        req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output j2dst_rsp_type             rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   logic [SIZE_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [DATA_W-1:0] stencil_scale_ff;
   j2dst_cfg_type     cfg;

   logic           cell_valid [N_CELLS+1];
   logic           cell_ready [N_CELLS+1];
   j2dst_cell_type cell_data  [N_CELLS+1];

   // Register writes; unknown indexes drop
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff     <= SIZE_RESET;
         grid_cols_ff     <= SIZE_RESET;
         stencil_scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_GRID_COLS:     grid_cols_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_STENCIL_SCALE: stencil_scale_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Clamp sizes into range and split the scale into sign and magnitude
   always_comb begin
      cfg.rows      = clamp_size(grid_rows_ff, MAX_ROWS);
      cfg.cols      = clamp_size(grid_cols_ff, MAX_COLS);
      cfg.scale_neg = stencil_scale_ff[DATA_W-1];
      cfg.scale_mag = cfg.scale_neg ? (~stencil_scale_ff + DATA_W'(1)) : stencil_scale_ff;
   end

   j2dst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_data  (cell_data[0])
   );

   // Multiply chain, most significant scale chunk first
   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      j2dst_mac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   j2dst_round_sat u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cell_valid[N_CELLS]),
      .in_ready  (cell_ready[N_CELLS]),
      .in_data   (cell_data[N_CELLS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // An empty output stage means every stage can move, so intake is open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output stage");

   // Only interior points are reported
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_row != '0) && (rsp_data.out_col != '0))
      else $error("result reported on a border row or column");

   // Reset leaves no result pending
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !cell_valid[0])
      else $error("result pending right after reset");

endmodule

`default_nettype wire
